### rtl/gtr_pkg.sv
// Shared types and constants for the two-net lattice router.
// Used by grid_two_net_bfs_router and its testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package gtr_pkg;

  localparam int GRID_SIDE       = 128;
  localparam int LEN_W           = 15;
  localparam int EPOCH_W         = 8;
  localparam int EPOCHS_PER_ITEM = 8;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CHECK,
    ST_ROUTE,
    ST_BLK1,
    ST_BLK2,
    ST_SRCH,
    ST_POP,
    ST_POPW,
    ST_NRD,
    ST_NWR,
    ST_TRD,
    ST_TWR,
    ST_ROK,
    ST_NEXT,
    ST_OUT
  } gtr_state_t;

endpackage
`default_nettype wire

### rtl/grid_two_net_bfs_router.sv
// Two-net maze router: sequencer, search datapath, grid and queue memories.
// Depends on gtr_pkg and gtr_ram.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken when start is high and busy is low; busy stays high until
// the cycle in which the result is shown. The result is on
// out_total_length/out_impossible for exactly one cycle with out_valid high and
// must be captured then. Each
// item runs up to four breadth-first searches and traces through one grid
// memory with one access a cycle: each expanded lattice point costs a queue
// pop plus a read and, if unvisited, a write per neighbor on the lattice, and
// each traced point a read and, on the first net, a write; an item with a pin
// off the lattice or shared between nets goes straight to its result.
// Visited and parent marks carry epoch tags, so no per-pass clearing is done;
// after reset, and whenever the epoch counter nears its top (at most about
// every 30th item), a sweep over all GRID_SIDE*GRID_SIDE words clears the
// grid memory while busy is high.
module grid_two_net_bfs_router #(
  parameter int GRID_SIDE = gtr_pkg::GRID_SIDE
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [6:0]                in_rows,
  input  wire logic [6:0]                in_cols,
  input  wire logic [6:0]                in_a_start_row,
  input  wire logic [6:0]                in_a_start_col,
  input  wire logic [6:0]                in_a_end_row,
  input  wire logic [6:0]                in_a_end_col,
  input  wire logic [6:0]                in_b_start_row,
  input  wire logic [6:0]                in_b_start_col,
  input  wire logic [6:0]                in_b_end_row,
  input  wire logic [6:0]                in_b_end_col,
  output logic                           out_valid,
  output logic [gtr_pkg::LEN_W-1:0]      out_total_length,
  output logic                           out_impossible
);
  import gtr_pkg::*;

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int QW = AW + 1;
  localparam int EW = EPOCH_W;
  localparam int WW = 2 * EW + AW;
  localparam int LW = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam logic [8:0] LIM = 9'(GRID_SIDE - 1);
  localparam logic [EW-1:0] EP_LIMIT = EW'((1 << EW) - 1 - EPOCHS_PER_ITEM);

  gtr_state_t state_r, state_nxt;

  logic [CW-1:0] nr_r, nr_nxt, nc_r, nc_nxt;
  logic [AW-1:0] pin_r [4];
  logic [AW-1:0] pin_nxt [4];
  logic          ok_r, ok_nxt;
  logic          pend_r, pend_nxt;
  logic          order_r, order_nxt;
  logic          net_r, net_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt, vep_r, vep_nxt, pep_r, pep_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, best_r, best_nxt;
  logic          best_ok_r, best_ok_nxt;
  logic          out_valid_r;
  logic [LEN_W-1:0] out_len_r;
  logic          out_imp_r;

  // Memory ports.
  logic          g_we, q_we;
  logic [AW-1:0] g_waddr, g_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [WW-1:0] g_wdata, g_rdata;

  gtr_ram #(.AW(AW), .DW(WW)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  gtr_ram #(.AW(AW), .DW(AW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Input saturation and pin checks.
  logic [8:0]    rows9, cols9, nr9, nc9;
  logic [6:0]    pr [4];
  logic [6:0]    pc [4];
  logic [AW-1:0] pin_in [4];
  logic          in_ok;
  always_comb begin
    rows9 = 9'(in_rows);
    cols9 = 9'(in_cols);
    nr9 = (rows9 > LIM) ? LIM : rows9;
    nc9 = (cols9 > LIM) ? LIM : cols9;
    pr[0] = in_a_start_row; pc[0] = in_a_start_col;
    pr[1] = in_a_end_row;   pc[1] = in_a_end_col;
    pr[2] = in_b_start_row; pc[2] = in_b_start_col;
    pr[3] = in_b_end_row;   pc[3] = in_b_end_col;
    in_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      pin_in[i] = {CW'(pr[i]), CW'(pc[i])};
      if (9'(pr[i]) > nr9 || 9'(pc[i]) > nc9) begin
        in_ok = 1'b0;
      end
    end
    if (pin_in[0] == pin_in[2] || pin_in[0] == pin_in[3] ||
        pin_in[1] == pin_in[2] || pin_in[1] == pin_in[3]) begin
      in_ok = 1'b0;
    end
  end

  // Pins of the current order: net x is routed first, net y is blocked.
  logic [AW-1:0] x1, x2, y1, y2, src, tgt;
  assign x1  = order_r ? pin_r[3] : pin_r[0];
  assign x2  = order_r ? pin_r[2] : pin_r[1];
  assign y1  = order_r ? pin_r[1] : pin_r[2];
  assign y2  = order_r ? pin_r[0] : pin_r[3];
  assign src = net_r ? y1 : x1;
  assign tgt = net_r ? y2 : x2;

  logic [EW-1:0] g_vtag, g_ptag;
  logic [AW-1:0] g_par;
  assign g_vtag = g_rdata[WW-1 -: EW];
  assign g_ptag = g_rdata[AW+EW-1 -: EW];
  assign g_par  = g_rdata[AW-1:0];

  // Neighbor of u in the current direction.
  logic [CW-1:0] ur, uc;
  logic [AW-1:0] nb;
  logic          nb_ok;
  assign ur = u_r[AW-1:CW];
  assign uc = u_r[CW-1:0];
  always_comb begin
    unique case (dir_r)
      DIR_UP: begin
        nb_ok = (ur != '0);
        nb    = {ur - CW'(1), uc};
      end
      DIR_LEFT: begin
        nb_ok = (uc != '0);
        nb    = {ur, uc - CW'(1)};
      end
      DIR_DOWN: begin
        nb_ok = (ur < nr_r);
        nb    = {ur + CW'(1), uc};
      end
      default: begin
        nb_ok = (uc < nc_r);
        nb    = {ur, uc + CW'(1)};
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: if (sweep_r == '1) state_nxt = pend_r ? ST_CHECK : ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!ok_r) state_nxt = ST_OUT;
        else if (epoch_r > EP_LIMIT) state_nxt = ST_SWEEP;
        else state_nxt = ST_ROUTE;
      end
      ST_ROUTE: state_nxt = ST_BLK1;
      ST_BLK1:  state_nxt = ST_BLK2;
      ST_BLK2:  state_nxt = ST_SRCH;
      ST_SRCH:  state_nxt = ST_POP;
      ST_POP:   state_nxt = (head_r == tail_r) ? ST_NEXT : ST_POPW;
      ST_POPW:  state_nxt = (q_rdata == tgt) ? ST_TRD : ST_NRD;
      ST_NRD: begin
        if (nb_ok) state_nxt = ST_NWR;
        else if (dir_r == DIR_RIGHT) state_nxt = ST_POP;
      end
      ST_NWR:   state_nxt = (dir_r == DIR_RIGHT) ? ST_POP : ST_NRD;
      ST_TRD:   state_nxt = ST_TWR;
      ST_TWR: begin
        if (g_ptag != pep_r) state_nxt = net_r ? ST_ROK : ST_SRCH;
        else state_nxt = ST_TRD;
      end
      ST_ROK:   state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = order_r ? ST_OUT : ST_ROUTE;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  logic [LW-1:0] len;
  assign len = cnt_r - LW'(2);

  always_comb begin
    nr_nxt = nr_r; nc_nxt = nc_r; ok_nxt = ok_r; pend_nxt = pend_r;
    for (int i = 0; i < 4; i++) pin_nxt[i] = pin_r[i];
    order_nxt = order_r; net_nxt = net_r;
    epoch_nxt = epoch_r; vep_nxt = vep_r; pep_nxt = pep_r;
    sweep_nxt = sweep_r; head_nxt = head_r; tail_nxt = tail_r;
    u_nxt = u_r; v_nxt = v_r; dir_nxt = dir_r;
    cnt_nxt = cnt_r; best_nxt = best_r; best_ok_nxt = best_ok_r;
    g_we = 1'b0; g_waddr = v_r; g_wdata = '0; g_raddr = u_r;
    q_we = 1'b0; q_waddr = tail_r[AW-1:0]; q_wdata = v_r;
    q_raddr = head_r[AW-1:0];
    unique case (state_r)
      ST_SWEEP: begin
        g_we = 1'b1;
        g_waddr = sweep_r;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == '1) begin
          epoch_nxt = '0;
          vep_nxt = '0;
          pep_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          nr_nxt = nr9[CW-1:0];
          nc_nxt = nc9[CW-1:0];
          for (int i = 0; i < 4; i++) pin_nxt[i] = pin_in[i];
          ok_nxt = in_ok;
          pend_nxt = 1'b1;
          order_nxt = 1'b0;
          best_ok_nxt = 1'b0;
        end
      end
      ST_ROUTE: begin
        epoch_nxt = epoch_r + EW'(1);
        vep_nxt = epoch_r + EW'(1);
        net_nxt = 1'b0;
        cnt_nxt = '0;
      end
      ST_BLK1: begin
        g_we = 1'b1;
        g_waddr = y1;
        g_wdata = {vep_r, EW'(0), AW'(0)};
      end
      ST_BLK2: begin
        g_we = 1'b1;
        g_waddr = y2;
        g_wdata = {vep_r, EW'(0), AW'(0)};
      end
      ST_SRCH: begin
        epoch_nxt = epoch_r + EW'(1);
        pep_nxt = epoch_r + EW'(1);
        g_we = 1'b1;
        g_waddr = src;
        g_wdata = {vep_r, EW'(0), AW'(0)};
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = src;
        head_nxt = '0;
        tail_nxt = QW'(1);
      end
      ST_POP: begin
        if (head_r != tail_r) head_nxt = head_r + QW'(1);
      end
      ST_POPW: begin
        u_nxt = q_rdata;
        dir_nxt = DIR_UP;
        if (q_rdata == tgt && !net_r) begin
          // The first net is found: start a fresh visited epoch so that
          // only its traced path stays blocked.
          epoch_nxt = epoch_r + EW'(1);
          vep_nxt = epoch_r + EW'(1);
        end
      end
      ST_NRD: begin
        g_raddr = nb;
        v_nxt = nb;
        if (!nb_ok) dir_nxt = dir_r + 2'd1;
      end
      ST_NWR: begin
        if (g_vtag != vep_r) begin
          g_we = 1'b1;
          g_waddr = v_r;
          g_wdata = {vep_r, pep_r, u_r};
          q_we = 1'b1;
          tail_nxt = tail_r + QW'(1);
        end
        dir_nxt = dir_r + 2'd1;
      end
      ST_TRD: begin
        g_raddr = u_r;
      end
      ST_TWR: begin
        if (!net_r) begin
          g_we = 1'b1;
          g_waddr = u_r;
          g_wdata = {vep_r, g_ptag, g_par};
        end
        cnt_nxt = cnt_r + LW'(1);
        if (g_ptag == pep_r) u_nxt = g_par;
        else if (!net_r) net_nxt = 1'b1;
      end
      ST_ROK: begin
        if (!best_ok_r || len < best_r) best_nxt = len;
        best_ok_nxt = 1'b1;
      end
      ST_NEXT: begin
        order_nxt = 1'b1;
      end
      ST_OUT: begin
        pend_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      pend_r      <= 1'b0;
      sweep_r     <= '0;
      epoch_r     <= '0;
      vep_r       <= '0;
      pep_r       <= '0;
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      sweep_r     <= sweep_nxt;
      epoch_r     <= epoch_nxt;
      vep_r       <= vep_nxt;
      pep_r       <= pep_nxt;
      out_valid_r <= (state_r == ST_OUT);
      best_ok_r   <= best_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nr_r <= nr_nxt;
    nc_r <= nc_nxt;
    for (int i = 0; i < 4; i++) pin_r[i] <= pin_nxt[i];
    ok_r    <= ok_nxt;
    order_r <= order_nxt;
    net_r   <= net_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    dir_r   <= dir_nxt;
    cnt_r   <= cnt_nxt;
    best_r  <= best_nxt;
    if (state_r == ST_OUT) begin
      out_len_r <= best_ok_r ? LEN_W'(best_r) : '0;
      out_imp_r <= !best_ok_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_total_length = out_len_r;
  assign out_impossible   = out_imp_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after an accepted item");
  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result shown without an item in work");
  a_impossible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_impossible |-> out_total_length == '0)
    else $error("impossible result with nonzero length");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POPW) |-> head_r <= tail_r)
    else $error("queue head ran past tail");
`endif

endmodule
`default_nettype wire

### rtl/gtr_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; instantiated by grid_two_net_bfs_router.
`timescale 1ns / 1ps
`default_nettype none
module gtr_ram #(
  parameter int AW = 14,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sim/tb_grid_two_net_bfs_router.sv
// Self-checking testbench for grid_two_net_bfs_router: directed and random
// routing problems, with a built-in breadth-first predictor. Needs gtr_pkg.
`timescale 1ns / 1ps
module tb_grid_two_net_bfs_router;
  localparam int SIDE = gtr_pkg::GRID_SIDE;
  localparam int NPTS = SIDE * SIDE;
  localparam int NUM_DIRECTED = 12;
  localparam int NUM_RANDOM = 100;

  typedef struct {
    logic [6:0] rows, cols, ar1, ac1, ar2, ac2, br1, bc1, br2, bc2;
  } problem_t;

  typedef struct {
    logic [gtr_pkg::LEN_W-1:0] length;
    logic                      impossible;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid, out_impossible;
  logic [gtr_pkg::LEN_W-1:0] out_total_length;
  logic [6:0] in_rows = '0, in_cols = '0;
  logic [6:0] in_a_start_row = '0, in_a_start_col = '0;
  logic [6:0] in_a_end_row = '0, in_a_end_col = '0;
  logic [6:0] in_b_start_row = '0, in_b_start_col = '0;
  logic [6:0] in_b_end_row = '0, in_b_end_col = '0;

  problem_t pending_problems[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int routed_ok = 0;
  int total_items = 0;
  bit drain_pause_done = 1'b0;

  // Predictor state.
  bit          seen[NPTS];
  bit          has_parent[NPTS];
  int unsigned parent_of[NPTS];
  int unsigned frontier[NPTS];

  grid_two_net_bfs_router dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_rows(in_rows), .in_cols(in_cols),
    .in_a_start_row(in_a_start_row), .in_a_start_col(in_a_start_col),
    .in_a_end_row(in_a_end_row), .in_a_end_col(in_a_end_col),
    .in_b_start_row(in_b_start_row), .in_b_start_col(in_b_start_col),
    .in_b_end_row(in_b_end_row), .in_b_end_col(in_b_end_col),
    .out_valid(out_valid), .out_total_length(out_total_length),
    .out_impossible(out_impossible)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_problem(problem_t p);
    pending_problems = {pending_problems, p};
  endfunction

  function automatic void mark_neighbor(int unsigned v, int unsigned u,
                                        ref int unsigned tail);
    if (v >= NPTS || seen[v] || tail >= NPTS) return;
    seen[v] = 1'b1;
    parent_of[v] = u;
    has_parent[v] = 1'b1;
    frontier[tail] = v;
    tail++;
  endfunction

  function automatic bit bfs_reach(int unsigned s, int unsigned t, int unsigned nr,
                                   int unsigned nc);
    int unsigned head, tail, u, r, c;
    head = 0;
    tail = 0;
    for (int i = 0; i < NPTS; i++) begin
      has_parent[i] = 1'b0;
      parent_of[i] = 0;
    end
    seen[s] = 1'b1;
    frontier[tail++] = s;
    while (head < tail) begin
      u = frontier[head++];
      r = u / SIDE;
      c = u % SIDE;
      if (u == t) return 1'b1;
      if (r > 0) mark_neighbor(u - SIDE, u, tail);
      if (c > 0) mark_neighbor(u - 1, u, tail);
      if (r < nr) mark_neighbor(u + SIDE, u, tail);
      if (c < nc) mark_neighbor(u + 1, u, tail);
    end
    return 1'b0;
  endfunction

  function automatic int unsigned trace_path(int unsigned t, bit block);
    int unsigned u, n;
    u = t;
    n = 0;
    while (n < NPTS) begin
      if (block) seen[u] = 1'b1;
      n++;
      if (!has_parent[u]) break;
      u = parent_of[u];
    end
    return n;
  endfunction

  function automatic bit route_order(int unsigned p1, int unsigned p2, int unsigned q1,
                                     int unsigned q2, int unsigned nr, int unsigned nc,
                                     output int unsigned len);
    int unsigned cnt;
    len = 0;
    for (int i = 0; i < NPTS; i++) seen[i] = 1'b0;
    seen[q1] = 1'b1;
    seen[q2] = 1'b1;
    if (!bfs_reach(p1, p2, nr, nc)) return 1'b0;
    for (int i = 0; i < NPTS; i++) seen[i] = 1'b0;
    cnt = trace_path(p2, 1'b1);
    if (!bfs_reach(q1, q2, nr, nc)) return 1'b0;
    cnt += trace_path(q2, 1'b0);
    len = cnt - 2;
    return 1'b1;
  endfunction

  function automatic answer_t predict_routing(problem_t p);
    answer_t a;
    int unsigned nr, nc, len, best;
    int unsigned pin[4];
    int unsigned pr[4], pc[4];
    bit ok, found;
    nr = p.rows;
    nc = p.cols;
    if (nr > SIDE - 1) nr = SIDE - 1;
    if (nc > SIDE - 1) nc = SIDE - 1;
    pr = '{p.ar1, p.ar2, p.br1, p.br2};
    pc = '{p.ac1, p.ac2, p.bc1, p.bc2};
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (pr[i] > nr || pc[i] > nc) begin
        ok = 1'b0;
        pin[i] = 0;
      end else begin
        pin[i] = pr[i] * SIDE + pc[i];
      end
    end
    if (ok && (pin[0] == pin[2] || pin[0] == pin[3] ||
               pin[1] == pin[2] || pin[1] == pin[3]))
      ok = 1'b0;
    found = 1'b0;
    best = 0;
    if (ok) begin
      if (route_order(pin[0], pin[1], pin[2], pin[3], nr, nc, len)) begin
        best = len;
        found = 1'b1;
      end
      if (route_order(pin[3], pin[2], pin[1], pin[0], nr, nc, len)) begin
        if (!found || len < best) best = len;
        found = 1'b1;
      end
    end
    a.length = found ? best[gtr_pkg::LEN_W-1:0] : '0;
    a.impossible = !found;
    return a;
  endfunction

  function automatic problem_t make_problem(int rows, int cols, int ar1, int ac1, int ar2,
                                            int ac2, int br1, int bc1, int br2, int bc2);
    problem_t p;
    p.rows = 7'(rows); p.cols = 7'(cols);
    p.ar1 = 7'(ar1); p.ac1 = 7'(ac1); p.ar2 = 7'(ar2); p.ac2 = 7'(ac2);
    p.br1 = 7'(br1); p.bc1 = 7'(bc1); p.br2 = 7'(br2); p.bc2 = 7'(bc2);
    return p;
  endfunction

  function automatic logic [6:0] random_coord(int unsigned lim);
    if ($urandom_range(0, 19) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, lim));
  endfunction

  function automatic problem_t random_problem();
    problem_t p;
    int unsigned spread;
    spread = ($urandom_range(0, 9) == 0) ? 24 : 7;
    p.rows = 7'($urandom_range(0, spread));
    p.cols = 7'($urandom_range(0, spread));
    p.ar1 = random_coord(p.rows); p.ac1 = random_coord(p.cols);
    p.ar2 = random_coord(p.rows); p.ac2 = random_coord(p.cols);
    p.br1 = random_coord(p.rows); p.bc1 = random_coord(p.cols);
    p.br2 = random_coord(p.rows); p.bc2 = random_coord(p.cols);
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH item %0d %s: got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  initial begin
    // Largest lattice, pins packed in the far corner so the searches stay short.
    add_problem(make_problem(127, 127, 127, 127, 127, 126, 126, 127, 125, 127));
    add_problem(make_problem(127, 127, 126, 126, 127, 125, 125, 126, 126, 124));
    // Every pin on one point: nets touch.
    add_problem(make_problem(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // A pin off the lattice.
    add_problem(make_problem(3, 3, 5, 0, 0, 0, 1, 1, 2, 2));
    add_problem(make_problem(3, 3, 0, 0, 1, 1, 2, 2, 3, 127));
    // Both nets single points.
    add_problem(make_problem(2, 2, 1, 1, 1, 1, 0, 0, 0, 0));
    // Single row where net B sits between the A pins: no order succeeds.
    add_problem(make_problem(0, 2, 0, 0, 0, 2, 0, 1, 0, 1));
    // A pin equal to a B pin in a roomy lattice.
    add_problem(make_problem(4, 4, 0, 0, 4, 4, 4, 4, 2, 0));
    // Crossing nets where no order fits.
    add_problem(make_problem(2, 2, 1, 0, 1, 2, 0, 1, 2, 1));
    add_problem(make_problem(5, 6, 0, 0, 5, 6, 0, 6, 5, 0));
    add_problem(make_problem(1, 1, 0, 0, 1, 1, 0, 1, 1, 0));
    add_problem(make_problem(6, 0, 0, 0, 6, 0, 3, 0, 3, 0));
    for (int i = 0; i < NUM_RANDOM; i++) add_problem(random_problem());
    total_items = pending_problems.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: holds the current item on the ports until it is taken.
  int idle_pct;
  bit taken;
  problem_t cur;
  always @(posedge clk) begin
    if (rst_n) begin
      taken = start && !busy;
      if (taken) begin
        expected_answers = {expected_answers, predict_routing(cur)};
        accepted++;
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (pending_problems.size() == 0) begin
        start <= 1'b0;
      end else if (accepted == NUM_DIRECTED && !drain_pause_done &&
                   expected_answers.size() != 0) begin
        start <= 1'b0;
      end else begin
        if (accepted >= NUM_DIRECTED) drain_pause_done = 1'b1;
        idle_pct = (accepted < total_items / 3) ? 36 :
                   (accepted < 2 * total_items / 3) ? 67 : 0;
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
        end else begin
          cur = pending_problems.pop_front();
          start <= 1'b1;
          in_rows <= cur.rows; in_cols <= cur.cols;
          in_a_start_row <= cur.ar1; in_a_start_col <= cur.ac1;
          in_a_end_row <= cur.ar2; in_a_end_col <= cur.ac2;
          in_b_start_row <= cur.br1; in_b_start_col <= cur.bc1;
          in_b_end_row <= cur.br2; in_b_end_col <= cur.bc2;
        end
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest prediction.
  answer_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", out_total_length, -1);
      end else begin
        want = expected_answers.pop_front();
        if (out_total_length !== want.length)
          report_mismatch("total_length", out_total_length, want.length);
        if (out_impossible !== want.impossible)
          report_mismatch("impossible", out_impossible, want.impossible);
        if (!want.impossible) routed_ok++;
      end
      checked++;
    end
  end

  initial begin
    @(posedge rst_n);
    while (pending_problems.size() != 0 || start || expected_answers.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d routing problems, %0d routable, %0d impossible.",
             checked, routed_ok, checked - routed_ok);
    if (errors == 0) begin
      $display("tb_grid_two_net_bfs_router: PASS");
    end else begin
      $display("tb_grid_two_net_bfs_router: FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_grid_two_net_bfs_router: FAIL");
    $finish;
  end
endmodule
